// File: src/mmbkc_pkg.sv
// shared types, constants and byte helpers for the multi-mode byte key cipher
// no dependencies; imported by every module of the block
package mmbkc_pkg;

  // widths of the fixed fields
  localparam int unsigned ByteW   = 8;
  localparam int unsigned PosW    = 11;
  localparam int unsigned KeyW    = 64;
  localparam int unsigned KeyBytes = KeyW / ByteW;
  localparam int unsigned KeySelW = $clog2(KeyBytes);
  localparam int unsigned CtrW    = PosW - KeySelW;
  localparam int unsigned CfgIdxW = 8;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgIdxKey  = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgIdxMode = 8'd1;

  // cipher constants
  localparam logic [ByteW-1:0] SubConst = 8'h3b;
  localparam logic [2:0]       RolFixed = 3'd6;

  // cipher rules
  typedef enum logic [2:0] {
    ModeXor       = 3'd0,
    ModeRorKey    = 3'd1,
    ModeRolKey    = 3'd2,
    ModeRol6      = 3'd3,
    ModeCtrXor    = 3'd4,
    ModeCtrDelta  = 3'd5,
    ModeCtrRorKey = 3'd6,
    ModeSubXor    = 3'd7
  } mode_e;

  // configuration held by the register bank
  typedef struct packed {
    logic [KeyBytes-1:0][ByteW-1:0] key;
    mode_e                          mode;
  } cfg_t;

  // one byte in the input stage with its message context
  typedef struct packed {
    logic [ByteW-1:0] plain;
    logic             last;
    logic [PosW-1:0]  pos;
    logic [ByteW-1:0] prev;
  } item_t;

  // rotate a byte right
  function automatic logic [ByteW-1:0] rotr8(logic [ByteW-1:0] v, logic [2:0] s);
    logic [2*ByteW-1:0] w;
    w = {v, v} >> s;
    return w[ByteW-1:0];
  endfunction

  // rotate a byte left
  function automatic logic [ByteW-1:0] rotl8(logic [ByteW-1:0] v, logic [2:0] s);
    logic [2*ByteW-1:0] w;
    w = {v, v} << s;
    return w[2*ByteW-1:ByteW];
  endfunction

endpackage

// File: src/mmbkc_cfg.sv
// configuration register bank: key and mode
// depends on mmbkc_pkg
module mmbkc_cfg
  import mmbkc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [KeyW-1:0]    cfg_data_i,
  output cfg_t               cfg_o
);

  logic [KeyW-1:0] key_q, key_d;
  mode_e           mode_q, mode_d;
  logic            wr_en;

  assign cfg_ready_o = 1'b1;
  assign wr_en       = cfg_valid_i & cfg_ready_o;

  // decode the register index; unknown indexes are dropped
  always_comb begin
    key_d  = key_q;
    mode_d = mode_q;
    if (wr_en) begin
      if (cfg_index_i == CfgIdxKey) begin
        key_d = cfg_data_i;
      end else if (cfg_index_i == CfgIdxMode) begin
        mode_d = mode_e'(cfg_data_i[2:0]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q  <= '0;
      mode_q <= ModeXor;
    end else begin
      key_q  <= key_d;
      mode_q <= mode_d;
    end
  end

  assign cfg_o.key  = key_q;
  assign cfg_o.mode = mode_q;

endmodule

// File: src/mmbkc_ctx.sv
// input stage: byte position and previous byte tracking, input register
// depends on mmbkc_pkg
module mmbkc_ctx
  import mmbkc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [ByteW-1:0] in_plain_i,
  input  logic             in_last_i,
  input  logic             advance_i,
  output logic             item_valid_o,
  output item_t            item_o
);

  logic            valid_q, valid_d;
  item_t           item_q;
  logic [PosW-1:0] pos_q, pos_d;
  logic [ByteW-1:0] prev_q, prev_d;
  logic            accept;

  // stage is free when empty or when its byte moves on this cycle
  assign in_ready_o = ~valid_q | advance_i;
  assign accept     = in_valid_i & in_ready_o;

  // message context follows each accepted byte
  always_comb begin
    pos_d   = pos_q;
    prev_d  = prev_q;
    valid_d = valid_q & ~advance_i;
    if (accept) begin
      valid_d = 1'b1;
      if (in_last_i) begin
        pos_d  = '0;
        prev_d = '0;
      end else begin
        pos_d  = pos_q + PosW'(1);
        prev_d = in_plain_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pos_q   <= '0;
      prev_q  <= '0;
    end else begin
      valid_q <= valid_d;
      pos_q   <= pos_d;
      prev_q  <= prev_d;
    end
  end

  // payload capture
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.plain <= in_plain_i;
      item_q.last  <= in_last_i;
      item_q.pos   <= pos_q;
      item_q.prev  <= prev_q;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

// File: src/mmbkc_enc.sv
// cipher rules and output register
// depends on mmbkc_pkg
module mmbkc_enc
  import mmbkc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  input  logic             item_valid_i,
  input  item_t            item_i,
  output logic             advance_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [ByteW-1:0] out_cipher_o,
  output logic             out_last_o
);

  logic             valid_q;
  logic [ByteW-1:0] cipher_q, cipher_d;
  logic             last_q;
  logic [ByteW-1:0] kb, kc, ctr8;
  logic [2:0]       rot;

  // output register is free when empty or taken this cycle
  assign advance_o = ~valid_q | out_ready_i;

  // key byte, counter and combined key
  assign kb   = cfg_i.key[item_i.pos[KeySelW-1:0]];
  assign ctr8 = ByteW'(item_i.pos[PosW-1:KeySelW]);
  assign kc   = kb + ctr8;
  assign rot  = kb[2:0];

  // one rule per mode
  always_comb begin
    unique case (cfg_i.mode)
      ModeXor:       cipher_d = item_i.plain ^ kb;
      ModeRorKey:    cipher_d = rotr8(item_i.plain ^ kb, rot);
      ModeRolKey:    cipher_d = rotl8(item_i.plain ^ kb, rot);
      ModeRol6:      cipher_d = rotl8(item_i.plain, RolFixed) ^ kb;
      ModeCtrXor:    cipher_d = item_i.plain ^ kc;
      ModeCtrDelta:  cipher_d = (item_i.plain - item_i.prev) ^ kc;
      ModeCtrRorKey: cipher_d = rotr8(item_i.plain ^ kc, rot);
      ModeSubXor:    cipher_d = (item_i.plain - SubConst) ^ kc;
      default:       cipher_d = item_i.plain ^ kb;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance_o) begin
      valid_q <= item_valid_i;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (advance_o && item_valid_i) begin
      cipher_q <= cipher_d;
      last_q   <= item_i.last;
    end
  end

  assign out_valid_o  = valid_q;
  assign out_cipher_o = cipher_q;
  assign out_last_o   = last_q;

endmodule

// File: src/multi_mode_byte_key_cipher.sv
// path: a byte accepted into the input register moves on to the output register,
//   from which it transfers on the master side
// throughput: one byte per cycle; the input register and the output register
//   each take a new byte whenever the stage after them is empty or moving
// reset: asynchronous, active low; clears key, mode, byte position, previous
//   byte and both stage valid flags
module multi_mode_byte_key_cipher
  import mmbkc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // plaintext stream
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [7:0]         s_axis_tdata_i,   // [7:0] plain_byte
  input  logic               s_axis_tlast_i,   // end_of_message
  // ciphertext stream
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  output logic [7:0]         m_axis_tdata_o,   // [7:0] cipher_byte
  output logic               m_axis_tlast_o,   // last_out
  // configuration writes
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [KeyW-1:0]    cfg_data_i
);

  cfg_t  cfg;
  item_t item;
  logic  item_valid;
  logic  advance;

  // register bank
  mmbkc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // input stage with message context
  mmbkc_ctx u_ctx (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_plain_i   (s_axis_tdata_i),
    .in_last_i    (s_axis_tlast_i),
    .advance_i    (advance),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  // cipher and output register
  mmbkc_enc u_enc (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .item_valid_i (item_valid),
    .item_i       (item),
    .advance_o    (advance),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_cipher_o (m_axis_tdata_o),
    .out_last_o   (m_axis_tlast_o)
  );

`ifndef SYNTHESIS
  // an empty input stage never stalls the slave side
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !item_valid |-> s_axis_tready_o)
    else $error("input stage empty but not ready");

  // an accepted byte lands in the input stage with its last flag
  a_capture_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> item_valid && (item.last == $past(s_axis_tlast_i)))
    else $error("accepted byte not captured");

  // a byte leaving the input stage becomes a valid result with its last flag
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_valid && advance |=> m_axis_tvalid_o && (m_axis_tlast_o == $past(item.last)))
    else $error("input stage byte lost on the way out");

  // the first byte after a message end starts at position zero
  a_pos_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && s_axis_tlast_i
      ##1 s_axis_tvalid_i && s_axis_tready_o |=> item.pos == '0)
    else $error("byte position not restarted after last byte");
`endif

endmodule

// File: dv/tb.sv
// testbench for multi_mode_byte_key_cipher: streams plaintext bytes under every cipher rule
// and checks each ciphertext byte against an in-bench predictor; depends on mmbkc_pkg
`timescale 1ns / 1ps

module tb;
  import mmbkc_pkg::*;

  // one ciphertext transfer as predicted
  typedef struct packed {
    logic [ByteW-1:0] cipher;
    logic             last;
  } cipher_result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [7:0]         s_tdata = 8'h00;    // [7:0] plain_byte
  logic               s_tlast = 1'b0;     // end_of_message
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [7:0]         m_tdata;            // [7:0] cipher_byte
  logic               m_tlast;            // last_out
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [KeyW-1:0]    cfg_data = '0;

  // predictor state and register copies
  logic [KeyW-1:0]  model_key = '0;
  mode_e            model_mode = ModeXor;
  logic [PosW-1:0]  model_pos = '0;
  logic [ByteW-1:0] model_prev = '0;

  cipher_result_t cipher_results[$];
  int unsigned    mismatch_count = 0;

  // sender pacing
  int unsigned burst_left = 0;
  int unsigned gap_max = 0;

  // receiver stall pattern
  int unsigned rx_cycle = 0;
  int unsigned rx_style = 0;
  logic [7:0]  rx_pattern = 8'hff;

  always #5 clk_i = ~clk_i;

  multi_mode_byte_key_cipher DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  // byte rotations, shift amount 0 leaves the byte as is
  function automatic logic [7:0] ror_byte(logic [7:0] v, logic [2:0] s);
    if (s == 3'd0) return v;
    return (v >> s) | (v << (4'd8 - s));
  endfunction

  function automatic logic [7:0] rol_byte(logic [7:0] v, logic [2:0] s);
    if (s == 3'd0) return v;
    return (v << s) | (v >> (4'd8 - s));
  endfunction

  // cipher one byte and advance the message position and previous byte
  function automatic cipher_result_t predict_cipher(logic [7:0] p, logic last);
    logic [7:0]     kb;
    logic [7:0]     ctr;
    logic [7:0]     kc;
    logic [7:0]     v;
    logic [2:0]     rot;
    cipher_result_t r;
    kb  = model_key[{model_pos[2:0], 3'b000} +: 8];
    ctr = model_pos[PosW-1:3];
    kc  = kb + ctr;
    rot = kb[2:0];
    case (model_mode)
      ModeXor:       v = p ^ kb;
      ModeRorKey:    v = ror_byte(p ^ kb, rot);
      ModeRolKey:    v = rol_byte(p ^ kb, rot);
      ModeRol6:      v = rol_byte(p, RolFixed) ^ kb;
      ModeCtrXor:    v = p ^ kc;
      ModeCtrDelta:  v = (p - model_prev) ^ kc;
      ModeCtrRorKey: v = ror_byte(p ^ kc, rot);
      default:       v = (p - SubConst) ^ kc;
    endcase
    r.cipher = v;
    r.last   = last;
    if (last) begin
      model_pos  = '0;
      model_prev = '0;
    end else begin
      model_pos  = model_pos + 1'b1;
      model_prev = p;
    end
    return r;
  endfunction

  // mode register word with random junk above the mode bits
  function automatic logic [KeyW-1:0] mode_word(mode_e m);
    logic [KeyW-1:0] w;
    w      = {$urandom, $urandom};
    w[2:0] = m;
    return w;
  endfunction

  // receiver: ready follows one of four stall styles, redrawn at random
  always @(posedge clk_i) begin
    rx_cycle++;
    if (rx_cycle % 256 == 0) begin
      rx_style   = $urandom_range(0, 3);
      rx_pattern = $urandom;
    end
    case (rx_style)
      0: m_tready <= 1'b1;
      1: m_tready <= $urandom_range(0, 1);
      2: m_tready <= ($urandom_range(0, 3) == 0);
      default: begin
        rx_pattern = {rx_pattern[6:0], rx_pattern[7]};
        m_tready <= rx_pattern[0];
      end
    endcase
  end

  // output check: a transfer seen at the falling edge completes at the next rising edge
  always @(negedge clk_i) begin : result_check
    cipher_result_t want;
    if (rst_ni && m_tvalid && m_tready) begin
      if (cipher_results.size() == 0) begin
        $display("%0t: unexpected transfer, expected none, actual cipher_byte %02h last_out %0b",
                 $time, m_tdata, m_tlast);
        mismatch_count++;
      end else begin
        want = cipher_results.pop_front();
        if (m_tdata !== want.cipher) begin
          $display("%0t: cipher_byte expected %02h actual %02h", $time, want.cipher, m_tdata);
          mismatch_count++;
        end
        if (m_tlast !== want.last) begin
          $display("%0t: last_out expected %0b actual %0b", $time, want.last, m_tlast);
          mismatch_count++;
        end
      end
    end
  end

  // send one plaintext byte, with a random gap before each burst
  task automatic send_byte(logic [7:0] p, logic last);
    int unsigned gap;
    logic        accepted;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= p;
    s_tlast  <= last;
    do begin
      @(negedge clk_i);
      accepted = s_tvalid && s_tready;
      @(posedge clk_i);
    end while (!accepted);
    cipher_results.push_back(predict_cipher(p, last));
  endtask

  // stop sending and wait until every predicted byte has come out
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (cipher_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // one register write transfer; valid stays high until cfg_release
  task automatic cfg_write(logic [CfgIdxW-1:0] idx, logic [KeyW-1:0] data);
    logic accepted;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do begin
      @(negedge clk_i);
      accepted = cfg_valid && cfg_ready;
      @(posedge clk_i);
    end while (!accepted);
    if (idx == CfgIdxKey) model_key = data;
    else if (idx == CfgIdxMode) model_mode = mode_e'(data[2:0]);
  endtask

  task automatic cfg_release();
    cfg_valid <= 1'b0;
  endtask

  // reset values: zero key and plain xor pass the bytes through
  task automatic test_reset_state();
    gap_max = 0;
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'h5a, 1'b1);
  endtask

  // every rule in turn on one message, so the position runs over all key bytes
  // and each rule change lands mid-message
  task automatic test_each_mode();
    mode_e m;
    drain_results();
    // rotation amounts 5, 3, 1, 0, 7, 0, 7, 0
    cfg_write(CfgIdxKey, 64'h00ff_0807_8001_3bc5);
    cfg_write(8'hff, {$urandom, $urandom});
    cfg_release();
    m = m.first();
    do begin
      drain_results();
      cfg_write(CfgIdxMode, mode_word(m));
      cfg_release();
      send_byte(8'h00, 1'b0);
      send_byte(8'hff, m == m.last());
      m = m.next();
    end while (m != m.first());
  endtask

  // random messages over all rules, keys and pacing
  task automatic test_random_traffic();
    logic [KeyW-1:0] key;
    logic [7:0]      p;
    mode_e           m;
    int unsigned     msg_left;
    m        = m.first();
    msg_left = 0;
    for (int phase = 0; phase < 16; phase++) begin
      drain_results();
      case (phase)
        0:       key = '0;
        1:       key = '1;
        default: key = {$urandom, $urandom};
      endcase
      cfg_write(CfgIdxKey, key);
      cfg_write(CfgIdxMode, mode_word(m));
      if ($urandom_range(0, 2) == 0) cfg_write(8'($urandom_range(2, 255)), {$urandom, $urandom});
      cfg_release();
      case ($urandom_range(0, 2))
        0:       gap_max = 0;
        1:       gap_max = 2;
        default: gap_max = 6;
      endcase
      burst_left = 0;
      for (int k = 0; k < 40; k++) begin
        if (msg_left == 0) msg_left = ($urandom_range(0, 5) == 0) ? 1 : $urandom_range(2, 24);
        case ($urandom_range(0, 7))
          0:       p = 8'h00;
          1:       p = 8'hff;
          default: p = $urandom;
        endcase
        msg_left--;
        send_byte(p, msg_left == 0);
        // sender holds off until the pipeline is empty
        if (phase == 5 && k == 30) drain_results();
      end
      m = m.next();
    end
  endtask

  // one long message so the counter runs over many values
  task automatic test_long_message();
    drain_results();
    cfg_write(CfgIdxKey, {$urandom, $urandom});
    cfg_write(CfgIdxMode, mode_word(ModeCtrRorKey));
    cfg_release();
    gap_max    = 0;
    burst_left = 0;
    for (int k = 0; k < 300; k++) send_byte(8'($urandom), k == 299);
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_each_mode();
    test_random_traffic();
    test_long_message();
    drain_results();
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0 && cipher_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// File: sim.f
src/mmbkc_pkg.sv
src/mmbkc_cfg.sv
src/mmbkc_ctx.sv
src/mmbkc_enc.sv
src/multi_mode_byte_key_cipher.sv
dv/tb.sv
